>>> rtl/mavr_pkg.sv
// mavr_pkg: shared constants and types for the moving average with ramp-up
// no dependencies; used by the front end and the top level
`default_nettype none

package mavr_pkg;

  // width and reset value of the window_taps register
  localparam int TAPS_W = 6;
  typedef logic [TAPS_W-1:0] taps_t;
  localparam taps_t TAPS_RESET = taps_t'(4);

endpackage

`default_nettype wire

>>> rtl/mavr_ram.sv
// mavr_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module mavr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [WIDTH-1:0]          wdata,
  input  wire logic [AW-1:0]             raddr,
  output logic      [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/mavr_queue.sv
// mavr_queue: two-entry command queue between the front end and the back end
// no dependencies
`default_nettype none

module mavr_queue #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             push;
  logic             pop;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/mavr_front.sv
// mavr_front: accepts samples, handles block restart, tracks ring slot and fill count
// depends on mavr_pkg; emits one command per sample into mavr_queue
`default_nettype none

module mavr_front #(
  parameter int MAX_TAPS    = 32,
  parameter int SAMPLE_BITS = 16,
  parameter int PTR_W       = 5,
  parameter int CNT_W       = 6,
  parameter int CMD_W       = 27
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                   in_first,
  input  wire mavr_pkg::taps_t        taps,
  output logic                        cmd_valid,
  input  wire logic                   cmd_ready,
  output logic      [CMD_W-1:0]       cmd_data
);

  logic [PTR_W-1:0] write_position;
  logic [CNT_W-1:0] fill_count;
  logic [PTR_W-1:0] slot;
  logic [PTR_W-1:0] write_position_next;
  logic [CNT_W-1:0] base_count;
  logic [CNT_W-1:0] fill_count_next;
  logic [CNT_W-1:0] eff_taps;
  logic [CNT_W-1:0] count;
  logic             accept;

  assign accept    = in_valid && in_ready;
  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;

  always_comb begin
    // a block start restarts the ring before this sample
    slot       = in_first ? '0 : write_position;
    base_count = in_first ? '0 : fill_count;
    write_position_next = (slot == PTR_W'(MAX_TAPS - 1)) ? '0 : slot + 1'b1;
    fill_count_next = (base_count == CNT_W'(MAX_TAPS)) ? base_count : base_count + 1'b1;
    if (taps == '0) begin
      eff_taps = CNT_W'(1);
    end else if (32'(taps) > MAX_TAPS) begin
      eff_taps = CNT_W'(MAX_TAPS);
    end else begin
      eff_taps = CNT_W'(taps);
    end
    count = (fill_count_next < eff_taps) ? fill_count_next : eff_taps;
  end

  // command: count in low bits, then ring slot, then sample
  assign cmd_data = {in_sample, slot, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
      fill_count     <= '0;
    end else if (accept) begin
      write_position <= write_position_next;
      fill_count     <= fill_count_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/mavr_back.sv
// mavr_back: writes the sample history, sums the window and divides by the count
// depends on mavr_ram; takes commands from mavr_queue, holds the output register
`default_nettype none

module mavr_back #(
  parameter int MAX_TAPS    = 32,
  parameter int SAMPLE_BITS = 16,
  parameter int PTR_W       = 5,
  parameter int CNT_W       = 6,
  parameter int CMD_W       = 27
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cmd_valid,
  output logic                        cmd_ready,
  input  wire logic [CMD_W-1:0]       cmd_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic      [SAMPLE_BITS-1:0] out_data
);

  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_TAPS);
  localparam int STEP_W = $clog2(SUM_W + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                    state;
  logic signed [SUM_W-1:0]       sum;
  logic [CNT_W-1:0]              issue_left;
  logic [PTR_W-1:0]              rd_addr;
  logic                          rd_pend;
  logic [CNT_W-1:0]              divisor;
  logic [CNT_W-1:0]              rem;
  logic [SUM_W-1:0]              quo;
  logic                          neg;
  logic [STEP_W-1:0]             step;

  logic [CNT_W-1:0]              cmd_count;
  logic [PTR_W-1:0]              cmd_slot;
  logic signed [SAMPLE_BITS-1:0] cmd_sample;
  logic                          pop;
  logic [SAMPLE_BITS-1:0]        ram_rdata;
  logic [CNT_W:0]                trial;
  logic                          fits;
  logic                          load;

  assign cmd_count  = cmd_data[CNT_W-1:0];
  assign cmd_slot   = cmd_data[CNT_W +: PTR_W];
  assign cmd_sample = $signed(cmd_data[CNT_W+PTR_W +: SAMPLE_BITS]);

  assign cmd_ready = (state == ST_IDLE);
  assign pop       = cmd_valid && cmd_ready;
  assign load      = (state == ST_DONE) && (!out_valid || out_ready);

  // restoring division step, one quotient bit per cycle
  assign trial = {rem, quo[SUM_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  function automatic logic [PTR_W-1:0] older(input logic [PTR_W-1:0] a);
    older = (a == '0) ? PTR_W'(MAX_TAPS - 1) : a - 1'b1;
  endfunction

  mavr_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_TAPS)
  ) u_hist (
    .clk   (clk),
    .we    (pop),
    .waddr (cmd_slot),
    .wdata (cmd_sample),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_pend <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pop) begin
            sum        <= SUM_W'(cmd_sample);
            issue_left <= cmd_count - 1'b1;
            rd_addr    <= older(cmd_slot);
            divisor    <= cmd_count;
            rd_pend    <= 1'b0;
            state      <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (issue_left != '0) begin
            rd_addr    <= older(rd_addr);
            issue_left <= issue_left - 1'b1;
            rd_pend    <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend) begin
            sum <= sum + SUM_W'($signed(ram_rdata));
          end
          if (issue_left == '0 && !rd_pend) begin
            neg   <= sum[SUM_W-1];
            quo   <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
            rem   <= '0;
            step  <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem  <= fits ? CNT_W'(trial - {1'b0, divisor}) : CNT_W'(trial);
          quo  <= {quo[SUM_W-2:0], fits};
          step <= step + 1'b1;
          if (step == STEP_W'(SUM_W - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= neg ? -quo[SAMPLE_BITS-1:0] : quo[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // a taken command always carries a nonzero count
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (divisor != '0))
    else $error("divisor is zero while busy");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < divisor))
    else $error("division remainder out of range");

  a_read_only_in_sum: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == ST_SUM))
    else $error("history read pending outside summing");

  // a mean of samples never exceeds the sample magnitude
  a_quotient_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (quo <= (SUM_W'(1) << (SAMPLE_BITS - 1))))
    else $error("quotient outside sample range");

endmodule

`default_nettype wire

>>> rtl/moving_average_with_rampup.sv
// moving_average_with_rampup: top level of the ramp-up moving average filter
// depends on mavr_pkg, mavr_front, mavr_queue, mavr_back (and mavr_ram below it)
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata: sample, tuser: first
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata: average
//  cfg       in         cfg_we (no wait)               cfg_wdata: window_taps
//
// for each item the back end sums count samples, where count is the number of samples
// averaged (up to MAX_TAPS), and then runs SUM_W = SAMPLE_BITS + clog2(MAX_TAPS)
// restoring division steps.
// the history ram has one read port, so the window is summed one sample per cycle.
// the front end accepts up to two items ahead of the back end through the queue,
// and the back end keeps working while the output register waits on m_axis_tready.
// reset (synchronous, active high) clears control state and sets window_taps to 4;
// the history ram is not cleared, only entries of the current block are read.
`default_nettype none

module moving_average_with_rampup #(
  parameter int MAX_TAPS    = 32,
  parameter int SAMPLE_BITS = 16,
  // tdata is the sample rounded up to whole bytes
  localparam int DATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // input samples
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [DATA_W-1:0]      s_axis_tdata,   // [SAMPLE_BITS-1:0] sample
  input  wire logic                   s_axis_tuser,   // [0] first
  // averages
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [DATA_W-1:0]      m_axis_tdata,   // [SAMPLE_BITS-1:0] average
  // window_taps register
  input  wire logic                   cfg_we,
  input  wire mavr_pkg::taps_t        cfg_wdata
);

  // ring slot and fill count widths
  localparam int PTR_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W  = $clog2(MAX_TAPS + 1);
  // command word: sample, ring slot, window count
  localparam int CMD_W  = SAMPLE_BITS + PTR_W + CNT_W;

  mavr_pkg::taps_t        window_taps;

  logic                   fq_valid;
  logic                   fq_ready;
  logic [CMD_W-1:0]       fq_data;
  logic                   qb_valid;
  logic                   qb_ready;
  logic [CMD_W-1:0]       qb_data;
  logic [SAMPLE_BITS-1:0] average;

  // the register should be written only while the filter is idle; the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      window_taps <= mavr_pkg::TAPS_RESET;
    end else if (cfg_we) begin
      window_taps <= cfg_wdata;
    end
  end

  // front end: block restart, ring slot, window count
  mavr_front #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .PTR_W       (PTR_W),
    .CNT_W       (CNT_W),
    .CMD_W       (CMD_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
    .in_first  (s_axis_tuser),
    .taps      (window_taps),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd_data  (fq_data)
  );

  // decouples the two halves so each can stall on its own
  mavr_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  // back end: history write, window sum, iterative divide, output register
  mavr_back #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .PTR_W       (PTR_W),
    .CNT_W       (CNT_W),
    .CMD_W       (CMD_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cmd_data  (qb_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (average)
  );

  // zero fill above the average
  assign m_axis_tdata = DATA_W'(average);

endmodule

`default_nettype wire
